@@ design/sha512_stream_hasher_macros.svh @@
// assertion helpers shared by the hasher files
// both expect clk and rst in scope and stay quiet during reset
`ifndef SHA512_STREAM_HASHER_MACROS_SVH
`define SHA512_STREAM_HASHER_MACROS_SVH

// condition in the same cycle
`define SHA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha512 hasher: same-cycle check failed");

// condition in the following cycle
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha512 hasher: next-cycle check failed");

`endif

@@ design/sha512_pkg.sv @@
package sha512_pkg;

  typedef logic [7:0][63:0] hash_t;

  typedef struct packed {
    logic        load;
    logic        start;
    logic        init;
    logic [63:0] word;
  } core_ctrl_t;

  typedef struct packed {
    logic  busy;
    hash_t hash;
  } core_stat_t;

  localparam logic [3:0] BLOCK_LAST_POS = 4'd15;
  localparam logic [3:0] LEN_HI_POS     = 4'd14;
  localparam logic [6:0] LAST_ROUND     = 7'd79;
  localparam logic [63:0] PAD_TOP       = 64'h8000_0000_0000_0000;

  localparam hash_t HASH_IV = '{
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
    64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
    64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  function automatic logic [63:0] round_k(input logic [6:0] r);
    logic [63:0] k;
    case (r)
      7'd0:  k = 64'h428a2f98d728ae22;
      7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;
      7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;
      7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;
      7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;
      7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;
      7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;
      7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;
      7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;
      7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;
      7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;
      7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;
      7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;
      7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;
      7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;
      7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;
      7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;
      7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;
      7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;
      7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;
      7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;
      7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;
      7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;
      7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;
      7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;
      7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;
      7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;
      7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;
      7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;
      7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;
      7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;
      7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;
      7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;
      7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;
      7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;
      7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;
      7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;
      7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;
      7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;
      7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;
      7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ design/sha512_core.sv @@
module sha512_core
  import sha512_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_ctrl_t ctrl,
  output core_stat_t stat
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

  cstate_t     state;
  logic [6:0]  rnd;
  hash_t       hash;
  hash_t       v;
  logic [15:0][63:0] w;

  logic [63:0] t1, t2, w_new;
  logic [63:0] big_s0, big_s1, ch, maj, sm_s0, sm_s1;

  function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one round per cycle, schedule as a 16-word shift line
  always_comb begin
    big_s1 = ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big_s0 = ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_s1 + ch + round_k(rnd) + w[0];
    t2     = big_s0 + maj;
    sm_s0  = ror(w[1], 1) ^ ror(w[1], 8) ^ (w[1] >> 7);
    sm_s1  = ror(w[14], 19) ^ ror(w[14], 61) ^ (w[14] >> 6);
    w_new  = w[0] + sm_s0 + w[9] + sm_s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      hash  <= HASH_IV;
    end else begin
      case (state)
        C_IDLE: begin
          if (ctrl.init) begin
            hash <= HASH_IV;
          end
          if (ctrl.start) begin
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == LAST_ROUND) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash[i] <= hash[i] + v[i];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == C_IDLE) begin
      if (ctrl.load) begin
        w <= {ctrl.word, w[15:1]};
      end
      if (ctrl.start) begin
        v <= hash;
      end
    end else if (state == C_ROUND) begin
      w <= {w_new, w[15:1]};
      v <= {v[6:4], v[3] + t1, v[2:0], t1 + t2};
    end
  end

  assign stat.busy = (state != C_IDLE);
  assign stat.hash = hash;

endmodule

@@ design/sha512_stream_hasher.sv @@
// sha512 stream hasher
// input channel: in_valid/in_ready move one message word (message_word, big
//   endian, valid_bytes, last). only the last word may be partial; a last word
//   with valid_bytes zero adds padding only, which hashes the empty message.
// output channel: out_valid/out_ready move the eight digest words, word_index
//   0 first, last_digest_word on index 7, too_long set if the byte count wrapped.
// flow: a word that does not fill a block is taken without a stall. the word
//   that fills a block starts a compression (80 rounds on the one round unit
//   plus the final state add), during which in_ready is low.
// after the last word the block pushes padding and length words one a cycle
//   while the core is idle and runs one or two more compressions, then offers
//   the digest words.
// in_ready stays low from the last word until the eighth digest word is taken;
//   a stalled receiver just holds the current digest word. after that the hash
//   state, word position and byte count return to their initial values.
// reset (rst, synchronous, active high) loads the initial hash values, clears
//   the byte count and overflow flag and drops out_valid.
`include "sha512_stream_hasher_macros.svh"

module sha512_stream_hasher
  import sha512_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_digest_word,
  output logic        too_long
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_ZERO, S_LEN_HI, S_LEN_LO, S_WAIT, S_OUT
  } state_t;

  state_t      state;
  logic [3:0]  pos;          // next free word slot in the block
  logic [63:0] byte_count;
  logic        overflow_seen;
  logic [2:0]  idx;

  core_ctrl_t  ctrl;
  core_stat_t  stat;

  logic        in_accept;
  logic [3:0]  eff_bytes;
  logic [64:0] count_sum;
  logic        push;
  logic [63:0] push_data;

  // keep the top nb bytes, put the 0x80 marker right after them
  function automatic logic [63:0] pad_word(input logic [63:0] word, input logic [3:0] nb);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nb) begin
        r[63 - 8*b -: 8] = word[63 - 8*b -: 8];
      end else if (4'(b) == nb) begin
        r[63 - 8*b -: 8] = 8'h80;
      end
    end
    return r;
  endfunction

  assign in_ready  = (state == S_IDLE) && !stat.busy;
  assign in_accept = in_valid && in_ready;

  // partial counts only matter on the last word; anything above 8 means 8
  assign eff_bytes = (!last || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
  assign count_sum = {1'b0, byte_count} + {61'b0, eff_bytes};

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          push      = 1'b1;
          push_data = (last && eff_bytes != 4'd8) ? pad_word(message_word, eff_bytes)
                                                  : message_word;
        end
      end
      S_PAD80: begin
        push      = !stat.busy;
        push_data = PAD_TOP;
      end
      S_ZERO: begin
        push      = !stat.busy && (pos != LEN_HI_POS);
        push_data = '0;
      end
      S_LEN_HI: begin
        push      = !stat.busy;
        push_data = {61'b0, byte_count[63:61]};
      end
      S_LEN_LO: begin
        push      = !stat.busy;
        push_data = {byte_count[60:0], 3'b0};
      end
      default: begin
        push      = 1'b0;
        push_data = '0;
      end
    endcase
  end

  // every push shifts a word in; the sixteenth of a block also starts rounds
  assign ctrl.load  = push;
  assign ctrl.start = push && (pos == BLOCK_LAST_POS);
  assign ctrl.init  = (state == S_OUT) && out_ready && (idx == 3'd7);
  assign ctrl.word  = push_data;

  sha512_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
      idx           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (push) begin
        pos <= pos + 4'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            byte_count <= count_sum[63:0];
            if (count_sum[64]) begin
              overflow_seen <= 1'b1;
            end
            if (last) begin
              state <= (eff_bytes == 4'd8) ? S_PAD80 : S_ZERO;
            end
          end
        end
        S_PAD80: begin
          if (!stat.busy) begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          // zero fill until the two length words close the block
          if (!stat.busy && pos == LEN_HI_POS) begin
            state <= S_LEN_HI;
          end
        end
        S_LEN_HI: begin
          if (!stat.busy) begin
            state <= S_LEN_LO;
          end
        end
        S_LEN_LO: begin
          if (!stat.busy) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!stat.busy) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
            idx       <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              out_valid     <= 1'b0;
              state         <= S_IDLE;
              byte_count    <= '0;
              overflow_seen <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest_word      = stat.hash[idx];
  assign word_index       = idx;
  assign last_digest_word = (idx == 3'd7);
  assign too_long         = overflow_seen;

  // no new message word while a digest is on offer
  `SHA_ASSERT_SAME(a_no_input_during_digest, out_valid, !in_ready)
  // digest words come only from a settled hash state
  `SHA_ASSERT_SAME(a_digest_core_idle, out_valid, !stat.busy)
  // a last word always hands the block over to padding
  `SHA_ASSERT_NEXT(a_last_closes_message, in_accept && last, !in_ready && !out_valid)
  // the final digest word leaves the counters clean for the next message
  `SHA_ASSERT_NEXT(a_clean_after_digest, out_valid && out_ready && last_digest_word,
                   byte_count == 64'd0 && !overflow_seen && pos == 4'd0)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // timing of the run
  localparam int DRAIN_CYCLES    = 200;   // longer than the slowest digest after a last word
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the block up
  localparam int PHASE_WORDS     = 26;    // random words per idling phase

  localparam logic [63:0] PAD_BYTE = 64'h80;

  // fips 180-4 initial hash value, word 0 first
  localparam logic [0:7][63:0] SHA_IV = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  // fips 180-4 round constants, round 0 first
  localparam logic [0:79][63:0] ROUND_K = {
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // one expected digest word
  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        is_last;
    logic        wrapped;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] message_word = '0;
  logic [3:0]  valid_bytes = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest_word;
  logic        too_long;

  // idling odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // cycles left in a forced receiver stall
  int hold_left = 0;
  int errors = 0;

  // predicted hasher state
  logic [63:0] hash_words [8];
  logic [63:0] block_words [16];
  int          fill_pos;
  logic [63:0] msg_bytes;
  logic        len_wrapped;

  digest_entry_t digest_expect [$];

  sha512_stream_hasher dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .message_word     (message_word),
    .valid_bytes      (valid_bytes),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .digest_word      (digest_word),
    .word_index       (word_index),
    .last_digest_word (last_digest_word),
    .too_long         (too_long)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sha-512 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // back to the initial values, as after a digest or a reset
  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hash_words[i] = SHA_IV[i];
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    fill_pos    = 0;
    msg_bytes   = '0;
    len_wrapped = 1'b0;
  endfunction

  // 80 rounds over block_words, schedule expanded in place
  function automatic void compress_block();
    logic [63:0] v [8];
    logic [63:0] x, y, t1, t2;
    int j;
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int r = 0; r < 80; r++) begin
      j = r % 16;
      if (r >= 16) begin
        x = block_words[(r - 15) % 16];
        y = block_words[(r - 2) % 16];
        block_words[j] = block_words[j]
                       + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7))
                       + block_words[(r - 7) % 16]
                       + (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6));
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + block_words[j];
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + v[i];
  endfunction

  // one word into the block, compress once it holds sixteen
  function automatic void absorb(input logic [63:0] w);
    block_words[fill_pos] = w;
    fill_pos++;
    if (fill_pos == 16) begin
      compress_block();
      fill_pos = 0;
    end
  endfunction

  // advance the predictor by one accepted word; a last word queues the digest
  function automatic void predict_word(input logic [63:0] w, input logic [3:0] vb,
                                       input logic lst);
    int            n;
    int            sh;
    logic [63:0]   prev;
    digest_entry_t e;
    n = vb;
    // byte count only honored on the last word, and never above eight
    if (n > 8 || !lst) n = 8;
    prev      = msg_bytes;
    msg_bytes = msg_bytes + 64'(n);
    if (msg_bytes < prev) len_wrapped = 1'b1;
    if (!lst) begin
      absorb(w);
      return;
    end
    if (n == 8) begin
      absorb(w);
      absorb(PAD_BYTE << 56);
    end else if (n == 0) begin
      absorb(PAD_BYTE << 56);
    end else begin
      // unused low bytes dropped, pad byte right after the data
      sh = (8 - n) * 8;
      absorb((w & ({64{1'b1}} << sh)) | (PAD_BYTE << (sh - 8)));
    end
    // no room for the length: finish this block with zeros
    if (fill_pos == 15) absorb('0);
    while (fill_pos < 14) absorb('0);
    absorb(msg_bytes >> 61);
    absorb(msg_bytes << 3);
    for (int k = 0; k < 8; k++) begin
      e.word    = hash_words[k];
      e.index   = 3'(k);
      e.is_last = (k == 7);
      e.wrapped = len_wrapped;
      digest_expect.push_back(e);
    end
    hash_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // offer one word, with random idle cycles ahead of it, and wait until taken
  // valid stays high on return so back to back words need no gap
  task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    message_word <= w;
    valid_bytes  <= vb;
    last         <= lst;
    do @(posedge clk); while (!in_ready);
    predict_word(w, vb, lst);
  endtask

  // one message of random words; non-last words carry junk byte counts
  task automatic send_message(input int nwords, input logic [3:0] last_vb);
    for (int i = 0; i < nwords - 1; i++)
      send_word(rand_word(), 4'($urandom_range(15)), 1'b0);
    send_word(rand_word(), last_vb, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random ready, forced stalls, and the digest check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : collect_digest
    digest_entry_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (digest_expect.size() == 0) begin
        $error("digest word with nothing expected: word_index %0d digest_word %h",
               word_index, digest_word);
        errors++;
      end else begin
        exp_word = digest_expect.pop_front();
        if (digest_word !== exp_word.word) begin
          $error("digest_word: expected %h, got %h", exp_word.word, digest_word);
          errors++;
        end
        if (word_index !== exp_word.index) begin
          $error("word_index: expected %0d, got %0d", exp_word.index, word_index);
          errors++;
        end
        if (last_digest_word !== exp_word.is_last) begin
          $error("last_digest_word: expected %b, got %b", exp_word.is_last,
                 last_digest_word);
          errors++;
        end
        if (too_long !== exp_word.wrapped) begin
          $error("too_long: expected %b, got %b", exp_word.wrapped, too_long);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero bytes on the last word: padding only, the empty-message hash
  task automatic test_empty_message();
    send_word(64'h0, 4'd0, 1'b1);
  endtask

  // single full word, all ones and all zeros
  task automatic test_word_extremes();
    send_word({64{1'b1}}, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
  endtask

  // partial last words of 1..7 bytes; all-ones data shows the unused bytes
  // are dropped and replaced by the pad
  task automatic test_partial_last_words();
    for (int n = 1; n < 8; n++)
      send_word({64{1'b1}}, 4'(n), 1'b1);
  endtask

  // short byte count on a non-last word is ignored, a count above eight on
  // the last word acts as eight
  task automatic test_ignored_byte_counts();
    send_word(rand_word(), 4'd3, 1'b0);
    send_word(rand_word(), 4'd15, 1'b1);
  endtask

  // receiver stalls for a long while; the second message backs up behind
  // the first digest and the block must hold its input off
  task automatic test_output_stall();
    hold_left = HOLD_OFF_CYCLES;
    send_message(2, 4'd8);
    send_message(3, 4'd5);
  endtask

  // random messages; most are short, some cross a block boundary so the
  // pad and length spill into an extra block
  task automatic run_random_phase(input int s_pct, input int r_pct, input int n_words);
    int sent;
    int pick;
    int len;
    logic [3:0] last_vb;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 20)
        len = 1;
      else if (pick < 75)
        len = $urandom_range(2, 12);
      else
        len = $urandom_range(13, 17);
      if ($urandom_range(99) < 40)
        last_vb = 4'd8;
      else
        last_vb = 4'($urandom_range(15));
      send_message(len, last_vb);
      sent += len;
    end
  endtask

  initial begin
    hash_restart();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 81;
    test_empty_message();
    test_word_extremes();
    test_partial_last_words();
    test_ignored_byte_counts();

    recv_idle_pct = 0;
    test_output_stall();

    run_random_phase(11, 81, PHASE_WORDS);
    run_random_phase(81, 11, PHASE_WORDS);
    run_random_phase(0, 0, PHASE_WORDS);

    // last word was taken this cycle
    in_valid <= 1'b0;
    while (digest_expect.size() != 0) @(posedge clk);
    // catch any stray digest words
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
